// File: sv/stuffed_crc16_frame_encoder_macros.svh
// Assertion helpers shared by the encoder modules.
// Each macro expects clk and rst_n in scope.
`ifndef STUFFED_CRC16_FRAME_ENCODER_MACROS_SVH
`define STUFFED_CRC16_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication.
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/scf_pkg.sv
`default_nettype none
package scf_pkg;

  localparam logic [7:0]  BYTE_END = 8'hFF;
  localparam logic [7:0]  BYTE_ESC = 8'hFE;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // One classified input beat, as handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic        frame_end;
    logic [15:0] crc;
    logic        esc_data;
    logic        esc_hi;
    logic        esc_lo;
  } job_t;

  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = (b == BYTE_END) || (b == BYTE_ESC);
  endfunction

  // Byte-wise CCITT update, poly 0x1021.
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]} ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    crc_next = c;
  endfunction

endpackage
`default_nettype wire

// File: sv/scf_front.sv
`default_nettype none
`include "stuffed_crc16_frame_encoder_macros.svh"
module scf_front
  import scf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_frame_end,
  output logic            push_valid,
  input  wire logic       push_ready,
  output job_t            push_job
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_upd;
  logic        accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign crc_upd    = crc_next(crc_r, in_data_byte);

  always_comb begin
    push_job.data      = in_data_byte;
    push_job.frame_end = in_frame_end;
    push_job.crc       = crc_upd;
    push_job.esc_data  = needs_escape(in_data_byte);
    push_job.esc_hi    = needs_escape(crc_upd[15:8]);
    push_job.esc_lo    = needs_escape(crc_upd[7:0]);
  end

  // Restart the CRC after the closing beat of a frame.
  always_comb begin
    crc_nxt = crc_r;
    if (accept) begin
      crc_nxt = in_frame_end ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  `SCF_ASSERT_NEXT(a_crc_restart, accept && in_frame_end, crc_r == CRC_INIT, "crc not restarted after frame end")

endmodule
`default_nettype wire

// File: sv/scf_queue.sv
`default_nettype none
`include "stuffed_crc16_frame_encoder_macros.svh"
module scf_queue
  import scf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      head_valid,
  output job_t      head_job,
  input  wire logic pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_nxt;
  logic            push;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign push       = push_valid && push_ready;
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `SCF_ASSERT_NOW(a_no_pop_empty, pop, head_valid, "pop from empty queue")
  `SCF_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CW'(DEPTH), "queue fill beyond depth")

endmodule
`default_nettype wire

// File: sv/scf_back.sv
`default_nettype none
`include "stuffed_crc16_frame_encoder_macros.svh"
module scf_back
  import scf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire job_t       head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_wire_byte,
  output logic            out_run_last
);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_HI,
    PH_LO,
    PH_END
  } phase_t;

  phase_t      phase_r;
  phase_t      phase_adv;
  logic        esc_sent_r;
  logic        out_valid_r;
  logic [7:0]  out_wire_byte_r;
  logic        out_run_last_r;
  logic [7:0]  cur_byte;
  logic        cur_esc;
  logic        emit_esc;
  logic [7:0]  emit_byte;
  logic        job_done;
  logic        load;

  always_comb begin
    case (phase_r)
      PH_DATA: begin
        cur_byte  = head_job.data;
        cur_esc   = head_job.esc_data;
        phase_adv = PH_HI;
      end
      PH_HI: begin
        cur_byte  = head_job.crc[15:8];
        cur_esc   = head_job.esc_hi;
        phase_adv = PH_LO;
      end
      PH_LO: begin
        cur_byte  = head_job.crc[7:0];
        cur_esc   = head_job.esc_lo;
        phase_adv = PH_END;
      end
      PH_END: begin
        cur_byte  = BYTE_END;
        cur_esc   = 1'b0;
        phase_adv = PH_DATA;
      end
      default: begin
        cur_byte  = head_job.data;
        cur_esc   = head_job.esc_data;
        phase_adv = PH_HI;
      end
    endcase
    emit_esc  = cur_esc && !esc_sent_r;
    emit_byte = emit_esc ? BYTE_ESC : cur_byte;
    job_done  = !emit_esc &&
                ((phase_r == PH_END) || ((phase_r == PH_DATA) && !head_job.frame_end));
    load      = head_valid && (!out_valid_r || out_ready);
  end

  assign pop           = load && job_done;
  assign out_valid     = out_valid_r;
  assign out_wire_byte = out_wire_byte_r;
  assign out_run_last  = out_run_last_r;

  // Emit one wire beat per load; hold the phase while an escape goes out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      esc_sent_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r     <= 1'b1;
      esc_sent_r      <= emit_esc;
      out_wire_byte_r <= emit_byte;
      out_run_last_r  <= job_done;
      if (job_done) begin
        phase_r <= PH_DATA;
      end else if (!emit_esc) begin
        phase_r <= phase_adv;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  `SCF_ASSERT_NOW(a_esc_shown, esc_sent_r, out_valid_r && (out_wire_byte_r == BYTE_ESC) && !out_run_last_r, "escape beat not in output register")
  `SCF_ASSERT_NOW(a_done_phase, pop, (phase_r == PH_END) || ((phase_r == PH_DATA) && !head_job.frame_end), "job retired in wrong phase")

endmodule
`default_nettype wire

// File: sv/stuffed_crc16_frame_encoder.sv
`default_nettype none
// Byte-stuffing frame encoder with CRC-16 trailer. Payload bytes enter one per
// input beat (in_frame_end on the last one of a frame) and go out as wire bytes,
// one per cycle while out_ready is high, with 0xFE put in front of any 0xFF or
// 0xFE; after the last byte follow the stuffed CRC-16 (poly 0x1021, init 0xFFFF,
// high byte first) and a raw 0xFF end marker, and the CRC restarts. An input beat
// yields 1 or 2 wire bytes (4 to 7 for the last byte of a frame), so the output
// link at one byte per cycle sets the rate; the first wire byte of a beat is
// registered in the queue, then in the output register. A queue of QUEUE_DEPTH
// classified beats sits between the CRC front end and the serializer, so input
// keeps flowing while out_ready is low until the queue fills.
module stuffed_crc16_frame_encoder
  import scf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_frame_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_wire_byte,
  output logic            out_run_last
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  scf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_job     (push_job)
  );

  scf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  scf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_wire_byte (out_wire_byte),
    .out_run_last  (out_run_last)
  );

endmodule
`default_nettype wire

// File: tb/stuffed_crc16_frame_encoder_tb.sv
`default_nettype none
module stuffed_crc16_frame_encoder_tb;
  import scf_pkg::*;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 410;
  localparam int HOLD_AT_ITEM = 250;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       run_last;
  } wire_beat_t;

  typedef enum {RX_STEADY, RX_COIN, RX_SLOW} rx_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_frame_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_wire_byte;
  logic       out_run_last;

  payload_t   payload_q[$];
  wire_beat_t wire_expect[$];
  logic [15:0] frame_crc;
  int         error_count;
  int         accepted_items;
  int         cycle_count;
  bit         in_fire;

  payload_t   next_item;
  int         burst_left;
  int         gap_left;

  rx_mode_t   rx_mode;
  int         stretch_left;
  int         hold_left;
  bit         hold_done;

  stuffed_crc16_frame_encoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_wire_byte(out_wire_byte),
    .out_run_last (out_run_last)
  );

  // Bit-serial CCITT update, MSB first.
  function automatic logic [15:0] ccitt_advance(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic push_stuffed(input logic [7:0] b, input logic last);
    if (b == BYTE_END || b == BYTE_ESC) begin
      wire_expect.push_back('{wire_byte: BYTE_ESC, run_last: 1'b0});
    end
    wire_expect.push_back('{wire_byte: b, run_last: last});
  endtask

  task automatic predict_wire_bytes(input logic [7:0] data, input logic last);
    push_stuffed(data, !last);
    frame_crc = ccitt_advance(frame_crc, data);
    if (last) begin
      push_stuffed(frame_crc[15:8], 1'b0);
      push_stuffed(frame_crc[7:0], 1'b0);
      wire_expect.push_back('{wire_byte: BYTE_END, run_last: 1'b1});
      frame_crc = CRC_INIT;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s mismatch: got %02h, expected %02h", $realtime, what, got, want);
    error_count++;
  endtask

  // Find a two-byte frame whose CRC has the given byte in the chosen half.
  function automatic logic [15:0] find_crc_frame(input bit check_hi, input logic [7:0] target);
    logic [15:0] c;
    int x;
    for (x = 0; x < 65536; x++) begin
      c = ccitt_advance(ccitt_advance(CRC_INIT, x[15:8]), x[7:0]);
      if ((check_hi ? c[15:8] : c[7:0]) == target) return x[15:0];
    end
    return 16'h0000;
  endfunction

  task automatic queue_frame(input logic [7:0] bytes[$]);
    int i;
    for (i = 0; i < bytes.size(); i++) begin
      payload_q.push_back('{data: bytes[i], last: (i == bytes.size() - 1)});
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic [15:0] pair;
    logic [7:0] frame[$];
    int len;
    int total;
    int i;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_frame_end = 1'b0;
    out_ready = 1'b0;
    frame_crc = CRC_INIT;
    error_count = 0;

    // Directed: single-byte frames (0x00, 0xFF, 0xFE, 0x55), a reserved-byte run,
    // and frames whose CRC bytes must be escaped.
    queue_frame('{8'h00});
    queue_frame('{BYTE_END});
    queue_frame('{BYTE_ESC});
    queue_frame('{8'h55});
    queue_frame('{8'h01, 8'h80, 8'h7F, 8'hFD, BYTE_ESC, BYTE_END, 8'h00});
    pair = find_crc_frame(1'b1, BYTE_END);
    queue_frame('{pair[15:8], pair[7:0]});
    pair = find_crc_frame(1'b1, BYTE_ESC);
    queue_frame('{pair[15:8], pair[7:0]});
    pair = find_crc_frame(1'b0, BYTE_END);
    queue_frame('{pair[15:8], pair[7:0]});
    pair = find_crc_frame(1'b0, BYTE_ESC);
    queue_frame('{pair[15:8], pair[7:0]});

    total = 0;
    while (total < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      frame.delete();
      for (i = 0; i < len; i++) begin
        frame.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(254, 255))
                                                    : 8'($urandom_range(0, 255)));
      end
      queue_frame(frame);
      total += len;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (payload_q.size() != 0 || in_valid) @(posedge clk);
    while (wire_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Monitor: note input beats for the driver, check every wire byte.
  always @(posedge clk) begin
    wire_beat_t want;
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      predict_wire_bytes(in_data_byte, in_frame_end);
      accepted_items++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (wire_expect.size() == 0) begin
        report_mismatch("unexpected wire byte", out_wire_byte, 8'h00);
      end else begin
        want = wire_expect.pop_front();
        if (out_wire_byte !== want.wire_byte)
          report_mismatch("wire_byte", out_wire_byte, want.wire_byte);
        if (out_run_last !== want.run_last)
          report_mismatch("run_last", {7'b0, out_run_last}, {7'b0, want.run_last});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Driver: bursts of beats separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      burst_left = $urandom_range(1, 6);
      gap_left = 0;
    end else if (in_valid && !in_fire) begin
      // hold the beat until taken
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (payload_q.size() != 0) begin
      next_item = payload_q.pop_front();
      in_data_byte <= next_item.data;
      in_frame_end <= next_item.last;
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 6);
        gap_left = $urandom_range(1, 8);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stretches of steady, coin-flip and slow readiness, plus one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stretch_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (!hold_done && accepted_items >= HOLD_AT_ITEM) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          stretch_left = $urandom_range(10, 120);
        end
        stretch_left--;
        case (rx_mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

endmodule
`default_nettype wire
